### hdl/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared codes, field widths and the floor-log2 encoder of the range-minimum
// engine.
// ----------------------------------------------------------------------------
package rmst_pkg;

    // field widths fixed by the word format
    localparam int unsigned POS_W = 10;
    localparam int unsigned DIN_W = 32;
    localparam int unsigned DOUT_W = 32;
    localparam int unsigned CFG_W = 11;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned LEN_W = POS_W + 1;
    localparam int unsigned K_W = 4;

    // operation codes (input tuser)
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // status codes (output tuser)
    localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_BUILT = 2'd2;

    // position of the highest set bit; 0 for an input of 0
    function automatic logic [K_W-1:0] floor_log2(input logic [LEN_W-1:0] v);
        logic [K_W-1:0] k;
        k = '0;
        for (int b = 1; b < LEN_W; b++) begin
            if (v[b]) begin
                k = K_W'(b);
            end
        end
        return k;
    endfunction

endpackage

### hdl/rmst_table_mem.sv
// ----------------------------------------------------------------------------
// rmst_table_mem
// Level table storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rmst_table_mem #(
    parameter int unsigned ADDR_W = 14,
    parameter int unsigned DEPTH  = 11264,
    parameter int unsigned DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [DATA_W-1:0] o_rd_data_a,
    output logic [DATA_W-1:0] o_rd_data_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

### hdl/rmst_min_unit.sv
// ----------------------------------------------------------------------------
// rmst_min_unit
// Shared signed minimum: used by the build walk and by queries.
// ----------------------------------------------------------------------------
module rmst_min_unit #(
    parameter int unsigned DATA_W = 32
) (
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic [DATA_W-1:0] o_min
);

    // ties keep operand a
    assign o_min = ($signed(i_a) <= $signed(i_b)) ? i_a : i_b;

endmodule

### hdl/range_minimum_sparse_table.sv
// ----------------------------------------------------------------------------
// range_minimum_sparse_table
// Sparse-table range-minimum engine with one shared compare unit.
// ----------------------------------------------------------------------------
// Load words write signed values into level 0 by position; positions at or
// above element_count are not written. The load marked tlast then starts the
// build. The build walks levels 1 up to the last level that fits
// element_count. Each level passes a check state, then for each table entry
// a read state (both halves from the dual-read table memory) and a write
// state (compare and write back). One more check state ends the walk. A
// query passes capture, range check and level encode, table read and
// compare. A query refused for an unbuilt table or a bad range is answered
// after the check. The result then waits in the output register until
// taken. The input is not ready while a build or query is running or a
// result is still waiting. The table memory has no reset; reading an
// element never loaded is undefined. Writing element_count, or any load,
// marks the table as not built.
// ----------------------------------------------------------------------------
module range_minimum_sparse_table
    import rmst_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = 1024,
    parameter int unsigned LEVELS       = 11,
    parameter int unsigned VALUE_WIDTH  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: element_count
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data,
    // input words
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [9:0] position, [41:10] element_value, [51:42] range_left,
    // [61:52] range_right, [63:62] zero
    input  logic [63:0]         s_axis_tdata,
    // [0] operation
    input  logic                s_axis_tuser,
    // last_element
    input  logic                s_axis_tlast,
    // result words
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [31:0] range_min
    output logic [DOUT_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [STAT_W-1:0]   m_axis_tuser
);

    localparam int unsigned IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned LA_W   = $clog2(LEVELS);
    localparam int unsigned LV_W   = $clog2(LEVELS + 1);
    localparam int unsigned SPAN_W = LEVELS + 1;
    localparam int unsigned ADDR_W = LA_W + IDX_W;
    localparam int unsigned DEPTH  = LEVELS << IDX_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_B_CHK = 3'd1;
    localparam logic [2:0] ST_B_RD  = 3'd2;
    localparam logic [2:0] ST_B_WR  = 3'd3;
    localparam logic [2:0] ST_Q_CHK = 3'd4;
    localparam logic [2:0] ST_Q_RD  = 3'd5;
    localparam logic [2:0] ST_Q_CMP = 3'd6;

    // field unpacking
    logic                    in_op;
    logic [POS_W-1:0]        in_pos;
    logic signed [DIN_W-1:0] in_val;
    logic [POS_W-1:0]        in_left;
    logic [POS_W-1:0]        in_right;
    logic                    in_acc;

    assign in_op    = s_axis_tuser;
    assign in_pos   = s_axis_tdata[9:0];
    assign in_val   = s_axis_tdata[41:10];
    assign in_left  = s_axis_tdata[51:42];
    assign in_right = s_axis_tdata[61:52];
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    // control and payload registers
    logic [2:0]             r_state, n_state;
    logic                   r_built, n_built;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_out_valid, n_out_valid;
    logic [DOUT_W-1:0]      r_out_min, n_out_min;
    logic [STAT_W-1:0]      r_out_stat, n_out_stat;
    logic [LV_W-1:0]        r_lvl, n_lvl;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [SPAN_W-1:0]      r_span, n_span;
    logic [POS_W-1:0]       r_left, n_left;
    logic [POS_W-1:0]       r_right, n_right;
    logic [LA_W-1:0]        r_k, n_k;

    // memory and compare unit hookup
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr_a;
    logic [ADDR_W-1:0]      mem_raddr_b;
    logic [VALUE_WIDTH-1:0] mem_rdata_a;
    logic [VALUE_WIDTH-1:0] mem_rdata_b;
    logic [VALUE_WIDTH-1:0] min_val;

    rmst_table_mem #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH),
        .DATA_W (VALUE_WIDTH)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (mem_we),
        .i_wr_addr   (mem_waddr),
        .i_wr_data   (mem_wdata),
        .i_rd_addr_a (mem_raddr_a),
        .i_rd_addr_b (mem_raddr_b),
        .o_rd_data_a (mem_rdata_a),
        .o_rd_data_b (mem_rdata_b)
    );

    rmst_min_unit #(
        .DATA_W (VALUE_WIDTH)
    ) u_min (
        .i_a   (mem_rdata_a),
        .i_b   (mem_rdata_b),
        .o_min (min_val)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_min;
    assign m_axis_tuser  = r_out_stat;

    // query helpers
    logic [LEN_W-1:0]  q_len;
    logic [K_W-1:0]    q_k_raw;
    logic              q_bad;
    logic [LEN_W-1:0]  q_bidx;
    logic [LV_W-1:0]   b_lvl_dn;
    logic [IDX_W-1:0]  b_half_idx;

    assign q_len   = LEN_W'(r_right) - LEN_W'(r_left) + LEN_W'(1);
    assign q_k_raw = floor_log2(q_len);
    assign q_bad   = (r_left > r_right) || (32'(r_right) >= 32'(r_count));
    assign q_bidx  = LEN_W'(r_right) + LEN_W'(1) - (LEN_W'(1) << r_k);
    assign b_lvl_dn   = r_lvl - LV_W'(1);
    assign b_half_idx = r_idx + IDX_W'(r_span >> 1);

    always_comb begin
        n_state     = r_state;
        n_built     = r_built;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_min   = r_out_min;
        n_out_stat  = r_out_stat;
        n_lvl       = r_lvl;
        n_idx       = r_idx;
        n_span      = r_span;
        n_left      = r_left;
        n_right     = r_right;
        n_k         = r_k;

        mem_we      = 1'b0;
        mem_waddr   = {LA_W'(0), IDX_W'(in_pos)};
        mem_wdata   = VALUE_WIDTH'(in_val);
        mem_raddr_a = {LA_W'(b_lvl_dn), r_idx};
        mem_raddr_b = {LA_W'(b_lvl_dn), b_half_idx};

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // clamp: 0 reads as 1, anything above the array size as the size
        if (i_cfg_valid && o_cfg_ready) begin
            n_built = 1'b0;
            if (i_cfg_data == '0) begin
                n_count = CNT_W'(1);
            end else if (32'(i_cfg_data) > 32'(MAX_ELEMENTS)) begin
                n_count = CNT_W'(MAX_ELEMENTS);
            end else begin
                n_count = CNT_W'(i_cfg_data);
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_op == OP_LOAD) begin
                        n_built = 1'b0;
                        mem_we  = 32'(in_pos) < 32'(r_count);
                        if (s_axis_tlast) begin
                            n_lvl   = LV_W'(1);
                            n_state = ST_B_CHK;
                        end
                    end else begin
                        n_left  = in_left;
                        n_right = in_right;
                        n_state = ST_Q_CHK;
                    end
                end
            end
            ST_B_CHK: begin
                n_span = SPAN_W'(1) << r_lvl;
                n_idx  = '0;
                if ((32'(r_lvl) >= 32'(LEVELS))
                        || (32'(SPAN_W'(1) << r_lvl) > 32'(r_count))) begin
                    n_built = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_B_RD;
                end
            end
            ST_B_RD: begin
                // read addresses are the default ones
                n_state = ST_B_WR;
            end
            ST_B_WR: begin
                mem_we    = 1'b1;
                mem_waddr = {LA_W'(r_lvl), r_idx};
                mem_wdata = min_val;
                if (32'(r_idx) + 32'd1 + 32'(r_span) <= 32'(r_count)) begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = ST_B_RD;
                end else begin
                    n_lvl   = r_lvl + LV_W'(1);
                    n_state = ST_B_CHK;
                end
            end
            ST_Q_CHK: begin
                if (!r_built) begin
                    n_out_valid = 1'b1;
                    n_out_min   = '0;
                    n_out_stat  = STAT_NOT_BUILT;
                    n_state     = ST_IDLE;
                end else if (q_bad) begin
                    n_out_valid = 1'b1;
                    n_out_min   = '0;
                    n_out_stat  = STAT_BAD_RANGE;
                    n_state     = ST_IDLE;
                end else begin
                    if (32'(q_k_raw) > 32'(LEVELS - 1)) begin
                        n_k = LA_W'(LEVELS - 1);
                    end else begin
                        n_k = LA_W'(q_k_raw);
                    end
                    n_state = ST_Q_RD;
                end
            end
            ST_Q_RD: begin
                mem_raddr_a = {r_k, IDX_W'(r_left)};
                mem_raddr_b = {r_k, IDX_W'(q_bidx)};
                n_state     = ST_Q_CMP;
            end
            ST_Q_CMP: begin
                n_out_valid = 1'b1;
                n_out_min   = DOUT_W'(min_val);
                n_out_stat  = STAT_OK;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_built     <= 1'b0;
            r_count     <= CNT_W'(MAX_ELEMENTS);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_min  <= n_out_min;
        r_out_stat <= n_out_stat;
        r_lvl      <= n_lvl;
        r_idx      <= n_idx;
        r_span     <= n_span;
        r_left     <= n_left;
        r_right    <= n_right;
        r_k        <= n_k;
    end

    // a query while the table is not built answers "not built"
    a_not_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (in_op == OP_QUERY) && !r_built)
            |-> ##2 (r_out_valid && (r_out_stat == STAT_NOT_BUILT)))
        else $error("query before build did not report not built");

    // the build never overwrites level 0
    a_build_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_B_WR) |-> (r_lvl != '0))
        else $error("build write aimed at level 0");

    // error results carry a zero minimum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_stat != STAT_OK)) |-> (r_out_min == '0))
        else $error("error result with non-zero minimum");

    // a finished query leaves exactly one word waiting
    a_cmp_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_CMP) |=> (r_out_valid && (r_out_stat == STAT_OK)))
        else $error("query result lost");

endmodule
